// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Depends on clock and reset signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SRTF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SRTF_ASSERT_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== hw/rtl/srtf_pkg.sv =====
// Shared constants and types for the SRTF tick scheduler.
// No dependencies.
`timescale 1ns / 1ps

package srtf_pkg;

   localparam int ID_BITS        = 8;
   localparam int PORT_TIME_BITS = 16;
   localparam int SUM_BITS       = 24;

   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

endpackage

// ===== hw/rtl/srtf_tick_scheduler_core.sv =====
// SRTF tick scheduler: job table in one RAM, scanned one entry per cycle.
// Depends on srtf_pkg, srtf_ram and assert_macros.svh.
// A load request fills the next free table entry, if any, and gives no response.
// A tick request scans with one RAM read per loaded entry, compares each entry
// on its registered read data, then writes back the picked entry and registers
// the response. Throughput is set by the single RAM read port. Synchronous reset
// empties the table and clears the clock and totals; table contents stay unwritten.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srtf_tick_scheduler_core #(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [srtf_pkg::ID_BITS-1:0]          req_job_id,
   input  logic [srtf_pkg::PORT_TIME_BITS-1:0]   req_arrival_time,
   input  logic [srtf_pkg::PORT_TIME_BITS-1:0]   req_burst_time,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_idle,
   output logic [srtf_pkg::ID_BITS-1:0]          rsp_run_id,
   output logic [srtf_pkg::PORT_TIME_BITS-1:0]   rsp_slot_time,
   output logic                                  rsp_job_done,
   output logic [srtf_pkg::PORT_TIME_BITS-1:0]   rsp_completion_time,
   output logic [srtf_pkg::PORT_TIME_BITS-1:0]   rsp_turnaround,
   output logic [srtf_pkg::PORT_TIME_BITS-1:0]   rsp_waiting,
   output logic                                  rsp_all_done,
   output logic [srtf_pkg::SUM_BITS-1:0]         rsp_total_waiting,
   output logic [srtf_pkg::SUM_BITS-1:0]         rsp_total_turnaround
);

   localparam int IDX_BITS = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_BITS = $clog2(MAX_JOBS + 1);
   localparam int TB       = TIME_BITS;
   localparam int ENTRY_W  = srtf_pkg::ID_BITS + 3 * TIME_BITS;
   localparam int SUM_W    = ((TIME_BITS > srtf_pkg::SUM_BITS) ? TIME_BITS
                                                               : srtf_pkg::SUM_BITS) + 1;
   localparam int SB       = srtf_pkg::SUM_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   state_type                      state_ff, state_in;
   logic [CNT_BITS-1:0]            loaded_ff, loaded_in;
   logic [CNT_BITS-1:0]            finished_ff, finished_in;
   logic [TB-1:0]                  now_ff, now_in;
   logic [SB-1:0]                  wsum_ff, wsum_in;
   logic [SB-1:0]                  tsum_ff, tsum_in;
   logic [CNT_BITS-1:0]            iss_ff, iss_in;
   logic                           rdv_ff, rdv_in;
   logic [IDX_BITS-1:0]            cmp_ff, cmp_in;
   logic                           found_ff, found_in;
   logic [IDX_BITS-1:0]            best_idx_ff, best_idx_in;
   logic [srtf_pkg::ID_BITS-1:0]   best_id_ff, best_id_in;
   logic [TB-1:0]                  best_arr_ff, best_arr_in;
   logic [TB-1:0]                  best_bur_ff, best_bur_in;
   logic [TB-1:0]                  best_rem_ff, best_rem_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           idle_ff, idle_in;
   logic [srtf_pkg::ID_BITS-1:0]   run_id_ff, run_id_in;
   logic [TB-1:0]                  slot_ff, slot_in;
   logic                           done_ff, done_in;
   logic [TB-1:0]                  comp_ff, comp_in;
   logic [TB-1:0]                  turn_ff, turn_in;
   logic [TB-1:0]                  wait_ff, wait_in;
   logic                           all_done_ff, all_done_in;

   logic                           ram_we;
   logic [IDX_BITS-1:0]            ram_wa;
   logic [ENTRY_W-1:0]             ram_wd;
   logic [IDX_BITS-1:0]            ram_ra;
   logic [ENTRY_W-1:0]             ram_rd;

   logic                           req_acc;
   logic                           tick_acc;
   logic                           issue;
   logic                           fin_fire;
   logic [srtf_pkg::ID_BITS-1:0]   rd_id;
   logic [TB-1:0]                  rd_arr, rd_bur, rd_rem;
   logic [TB-1:0]                  comp_w, rem_dec, turn_w, wait_w;
   logic                           fin_done;
   logic [SUM_W-1:0]               wsum_w, tsum_w;
   logic [CNT_BITS-1:0]            fin_cnt_w;

   srtf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_JOBS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign tick_acc  = req_acc && (req_op == srtf_pkg::OP_TICK);

   assign rd_rem = ram_rd[TB-1:0];
   assign rd_bur = ram_rd[2*TB-1:TB];
   assign rd_arr = ram_rd[3*TB-1:2*TB];
   assign rd_id  = ram_rd[ENTRY_W-1:3*TB];

   assign issue    = (state_ff == ST_SCAN) && (iss_ff < loaded_ff);
   assign ram_ra   = iss_ff[IDX_BITS-1:0];
   assign fin_fire = (state_ff == ST_FIN) && !(rsp_valid_ff && rsp_stall);

   assign comp_w    = (&now_ff) ? now_ff : now_ff + TB'(1);
   assign rem_dec   = best_rem_ff - TB'(1);
   assign fin_done  = found_ff && (rem_dec == '0);
   assign turn_w    = (comp_w >= best_arr_ff) ? comp_w - best_arr_ff : '0;
   assign wait_w    = (turn_w >= best_bur_ff) ? turn_w - best_bur_ff : '0;
   assign wsum_w    = SUM_W'(wsum_ff) + SUM_W'(wait_w);
   assign tsum_w    = SUM_W'(tsum_ff) + SUM_W'(turn_w);
   assign fin_cnt_w = fin_done ? finished_ff + CNT_BITS'(1) : finished_ff;

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      finished_in  = finished_ff;
      now_in       = now_ff;
      wsum_in      = wsum_ff;
      tsum_in      = tsum_ff;
      iss_in       = iss_ff;
      rdv_in       = 1'b0;
      cmp_in       = cmp_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_id_in   = best_id_ff;
      best_arr_in  = best_arr_ff;
      best_bur_in  = best_bur_ff;
      best_rem_in  = best_rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      idle_in      = idle_ff;
      run_id_in    = run_id_ff;
      slot_in      = slot_ff;
      done_in      = done_ff;
      comp_in      = comp_ff;
      turn_in      = turn_ff;
      wait_in      = wait_ff;
      all_done_in  = all_done_ff;
      ram_we       = 1'b0;
      ram_wa       = loaded_ff[IDX_BITS-1:0];
      ram_wd       = {req_job_id, TB'(req_arrival_time), TB'(req_burst_time),
                      TB'(req_burst_time)};

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_op == srtf_pkg::OP_TICK) begin
                  iss_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else if (loaded_ff < CNT_BITS'(MAX_JOBS)) begin
                  ram_we    = 1'b1;
                  loaded_in = loaded_ff + CNT_BITS'(1);
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rdv_in = 1'b1;
               cmp_in = iss_ff[IDX_BITS-1:0];
               iss_in = iss_ff + CNT_BITS'(1);
            end else begin
               state_in = ST_FIN;
            end
            if (rdv_ff && (rd_arr <= now_ff) && (rd_rem != '0) &&
                (!found_ff || (rd_rem < best_rem_ff))) begin
               found_in    = 1'b1;
               best_idx_in = cmp_ff;
               best_id_in  = rd_id;
               best_arr_in = rd_arr;
               best_bur_in = rd_bur;
               best_rem_in = rd_rem;
            end
         end
         ST_FIN: begin
            if (fin_fire) begin
               ram_we       = found_ff;
               ram_wa       = best_idx_ff;
               ram_wd       = {best_id_ff, best_arr_ff, best_bur_ff, rem_dec};
               rsp_valid_in = 1'b1;
               idle_in      = !found_ff;
               run_id_in    = found_ff ? best_id_ff : '0;
               slot_in      = now_ff;
               done_in      = fin_done;
               comp_in      = fin_done ? comp_w : '0;
               turn_in      = fin_done ? turn_w : '0;
               wait_in      = fin_done ? wait_w : '0;
               all_done_in  = (fin_cnt_w == loaded_ff);
               finished_in  = fin_cnt_w;
               if (fin_done) begin
                  wsum_in = (wsum_w[SUM_W-1:SB] != '0) ? srtf_pkg::SUM_MAX : wsum_w[SB-1:0];
                  tsum_in = (tsum_w[SUM_W-1:SB] != '0) ? srtf_pkg::SUM_MAX : tsum_w[SB-1:0];
               end
               now_in   = comp_w;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         finished_ff  <= '0;
         now_ff       <= '0;
         wsum_ff      <= '0;
         tsum_ff      <= '0;
         iss_ff       <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         finished_ff  <= finished_in;
         now_ff       <= now_in;
         wsum_ff      <= wsum_in;
         tsum_ff      <= tsum_in;
         iss_ff       <= iss_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_ff      <= cmp_in;
      best_idx_ff <= best_idx_in;
      best_id_ff  <= best_id_in;
      best_arr_ff <= best_arr_in;
      best_bur_ff <= best_bur_in;
      best_rem_ff <= best_rem_in;
      idle_ff     <= idle_in;
      run_id_ff   <= run_id_in;
      slot_ff     <= slot_in;
      done_ff     <= done_in;
      comp_ff     <= comp_in;
      turn_ff     <= turn_in;
      wait_ff     <= wait_in;
      all_done_ff <= all_done_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_idle             = idle_ff;
   assign rsp_run_id           = run_id_ff;
   assign rsp_slot_time        = srtf_pkg::PORT_TIME_BITS'(slot_ff);
   assign rsp_job_done         = done_ff;
   assign rsp_completion_time  = srtf_pkg::PORT_TIME_BITS'(comp_ff);
   assign rsp_turnaround       = srtf_pkg::PORT_TIME_BITS'(turn_ff);
   assign rsp_waiting          = srtf_pkg::PORT_TIME_BITS'(wait_ff);
   assign rsp_all_done         = all_done_ff;
   assign rsp_total_waiting    = wsum_ff;
   assign rsp_total_turnaround = tsum_ff;

   `SRTF_ASSERT(a_finished_le_loaded, finished_ff <= loaded_ff, "finished count passed loaded count")
   `SRTF_ASSERT(a_tick_starts_scan, tick_acc |=> (state_ff == ST_SCAN), "tick request did not start a scan")
   `SRTF_ASSERT(a_best_in_table, (state_ff == ST_FIN && found_ff) |-> (CNT_BITS'(best_idx_ff) < loaded_ff), "picked slot outside loaded table")
   `SRTF_ASSERT_ANY(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")

endmodule

// ===== hw/rtl/srtf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module srtf_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sim/srtf_tick_scheduler_core_test.sv =====
// Self-checking testbench for srtf_tick_scheduler_core: loads jobs, runs scheduling ticks
// with random gaps and stalls, and checks every response against an in-bench SRTF predictor.
// Depends on srtf_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module srtf_tick_scheduler_core_test;

   localparam int ID_BITS        = srtf_pkg::ID_BITS;
   localparam int PORT_TIME_BITS = srtf_pkg::PORT_TIME_BITS;
   localparam int SUM_BITS       = srtf_pkg::SUM_BITS;

   localparam int JOB_SLOTS    = 16;
   localparam int RANDOM_ITEMS = 350;
   localparam int EARLY_JOBS   = 10;
   localparam int DRAIN_CYCLES = 40;
   localparam int RUN_LIMIT    = 200_000;
   localparam logic [PORT_TIME_BITS-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic                      hold;
      logic                      calm;
      srtf_pkg::op_type          op;
      logic [ID_BITS-1:0]        job_id;
      logic [PORT_TIME_BITS-1:0] arrival;
      logic [PORT_TIME_BITS-1:0] burst;
   } job_req_type;

   typedef struct packed {
      logic                      idle;
      logic [ID_BITS-1:0]        run_id;
      logic [PORT_TIME_BITS-1:0] slot_time;
      logic                      job_done;
      logic [PORT_TIME_BITS-1:0] completion_time;
      logic [PORT_TIME_BITS-1:0] turnaround;
      logic [PORT_TIME_BITS-1:0] waiting;
      logic                      all_done;
      logic [SUM_BITS-1:0]       total_waiting;
      logic [SUM_BITS-1:0]       total_turnaround;
   } slot_report_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_op;
   logic [ID_BITS-1:0]        req_job_id;
   logic [PORT_TIME_BITS-1:0] req_arrival_time;
   logic [PORT_TIME_BITS-1:0] req_burst_time;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_idle;
   logic [ID_BITS-1:0]        rsp_run_id;
   logic [PORT_TIME_BITS-1:0] rsp_slot_time;
   logic                      rsp_job_done;
   logic [PORT_TIME_BITS-1:0] rsp_completion_time;
   logic [PORT_TIME_BITS-1:0] rsp_turnaround;
   logic [PORT_TIME_BITS-1:0] rsp_waiting;
   logic                      rsp_all_done;
   logic [SUM_BITS-1:0]       rsp_total_waiting;
   logic [SUM_BITS-1:0]       rsp_total_turnaround;

   job_req_type  cur_req        = '0;
   logic         calm_phase     = 1'b0;
   logic [1:0]   gap_left       = '0;
   logic [1:0]   stall_left     = '0;
   int           ticks_accepted = 0;
   int           rsp_count      = 0;
   int           cycle_count    = 0;
   int           mismatches     = 0;
   int           now_gen        = 0;
   int           loaded_gen     = 0;

   job_req_type     request_backlog[$];
   slot_report_type slot_reports_due[$];

   logic [ID_BITS-1:0]        tbl_id[JOB_SLOTS];
   logic [PORT_TIME_BITS-1:0] tbl_arr[JOB_SLOTS];
   logic [PORT_TIME_BITS-1:0] tbl_burst[JOB_SLOTS];
   logic [PORT_TIME_BITS-1:0] tbl_left[JOB_SLOTS];
   int                        n_loaded   = 0;
   int                        n_finished = 0;
   logic [PORT_TIME_BITS-1:0] clk_now    = '0;
   logic [SUM_BITS-1:0]       sum_wait   = '0;
   logic [SUM_BITS-1:0]       sum_turn   = '0;

   assign req_op           = cur_req.op;
   assign req_job_id       = cur_req.job_id;
   assign req_arrival_time = cur_req.arrival;
   assign req_burst_time   = cur_req.burst;

   srtf_tick_scheduler_core #(
      .MAX_JOBS (JOB_SLOTS),
      .TIME_BITS(PORT_TIME_BITS)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_job_id          (req_job_id),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_idle            (rsp_idle),
      .rsp_run_id          (rsp_run_id),
      .rsp_slot_time       (rsp_slot_time),
      .rsp_job_done        (rsp_job_done),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround      (rsp_turnaround),
      .rsp_waiting         (rsp_waiting),
      .rsp_all_done        (rsp_all_done),
      .rsp_total_waiting   (rsp_total_waiting),
      .rsp_total_turnaround(rsp_total_turnaround)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] a,
                                                   input logic [PORT_TIME_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + (SUM_BITS+1)'(b);
      return s[SUM_BITS] ? srtf_pkg::SUM_MAX : s[SUM_BITS-1:0];
   endfunction

   function automatic void advance_schedule(input job_req_type r);
      slot_report_type res;
      int              pick;
      if (r.op == srtf_pkg::OP_LOAD) begin
         if (n_loaded < JOB_SLOTS) begin
            tbl_id[n_loaded]    = r.job_id;
            tbl_arr[n_loaded]   = r.arrival;
            tbl_burst[n_loaded] = r.burst;
            tbl_left[n_loaded]  = r.burst;
            n_loaded++;
         end
         return;
      end
      pick = -1;
      for (int i = 0; i < n_loaded; i++)
         if (tbl_arr[i] <= clk_now && tbl_left[i] != 0 &&
             (pick < 0 || tbl_left[i] < tbl_left[pick]))
            pick = i;
      res           = '0;
      res.idle      = (pick < 0);
      res.slot_time = clk_now;
      if (pick >= 0) begin
         res.run_id = tbl_id[pick];
         tbl_left[pick] = tbl_left[pick] - 1'b1;
         if (tbl_left[pick] == 0) begin
            res.job_done        = 1'b1;
            res.completion_time = (clk_now == TIME_MAX) ? clk_now : clk_now + 1'b1;
            res.turnaround      = (res.completion_time >= tbl_arr[pick]) ?
                                  res.completion_time - tbl_arr[pick] : '0;
            res.waiting         = (res.turnaround >= tbl_burst[pick]) ?
                                  res.turnaround - tbl_burst[pick] : '0;
            n_finished++;
            sum_wait = sat_sum(sum_wait, res.waiting);
            sum_turn = sat_sum(sum_turn, res.turnaround);
         end
      end
      res.all_done         = (n_finished == n_loaded);
      res.total_waiting    = sum_wait;
      res.total_turnaround = sum_turn;
      if (clk_now != TIME_MAX)
         clk_now = clk_now + 1'b1;
      slot_reports_due = {slot_reports_due, res};
   endfunction

   function automatic void push_load(input logic [ID_BITS-1:0] id,
                                     input logic [PORT_TIME_BITS-1:0] arr,
                                     input logic [PORT_TIME_BITS-1:0] burst,
                                     input logic hold, input logic calm);
      job_req_type item;
      item = '{hold: hold, calm: calm, op: srtf_pkg::OP_LOAD, job_id: id, arrival: arr,
               burst: burst};
      request_backlog = {request_backlog, item};
      if (loaded_gen < JOB_SLOTS)
         loaded_gen++;
   endfunction

   function automatic void push_tick(input logic hold, input logic calm);
      job_req_type item;
      item.hold    = hold;
      item.calm    = calm;
      item.op      = srtf_pkg::OP_TICK;
      item.job_id  = ID_BITS'($urandom_range(0, 255));
      item.arrival = PORT_TIME_BITS'($urandom_range(0, 65535));
      item.burst   = PORT_TIME_BITS'($urandom_range(0, 65535));
      request_backlog = {request_backlog, item};
      if (now_gen < int'(TIME_MAX))
         now_gen++;
   endfunction

   function automatic void random_load(input logic hold, input logic calm);
      logic [PORT_TIME_BITS-1:0] arr;
      logic [PORT_TIME_BITS-1:0] burst;
      int                        mode;
      mode = $urandom_range(0, 9);
      if (mode < 7)
         arr = PORT_TIME_BITS'(now_gen + $urandom_range(0, 30));
      else if (mode < 9)
         arr = PORT_TIME_BITS'($urandom_range(0, now_gen));
      else
         arr = PORT_TIME_BITS'($urandom_range(0, 65535));
      mode = $urandom_range(0, 9);
      if (mode < 6)
         burst = PORT_TIME_BITS'($urandom_range(1, 40));
      else if (mode < 9)
         burst = PORT_TIME_BITS'($urandom_range(41, 200));
      else
         burst = PORT_TIME_BITS'($urandom_range(1, 65535));
      push_load(ID_BITS'($urandom_range(0, 255)), arr, burst, hold, calm);
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      $display("mismatch on %s at response %0d: got %0h, want %0h",
               what, rsp_count, got, want);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("srtf_tick_scheduler_core regression: fail");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      logic       valid_nxt;
      logic [1:0] gap_nxt;
      valid_nxt = req_valid;
      gap_nxt   = gap_left;
      if (reset) begin
         valid_nxt = 1'b0;
         gap_nxt   = '0;
      end else if (req_valid && !req_stall) begin
         advance_schedule(cur_req);
         if (cur_req.op == srtf_pkg::OP_TICK)
            ticks_accepted <= ticks_accepted + 1;
         valid_nxt = 1'b0;
         if (!calm_phase && !cycle_count[9] && $urandom_range(0, 4) == 0)
            gap_nxt = 2'($urandom_range(1, 3));
      end else if (!req_valid && gap_nxt != 0) begin
         gap_nxt = gap_nxt - 1'b1;
      end
      if (!reset && !valid_nxt && gap_nxt == 0 && request_backlog.size() != 0 &&
          (!request_backlog[0].hold || (!req_valid && ticks_accepted == rsp_count))) begin
         cur_req    <= request_backlog[0];
         calm_phase <= request_backlog[0].calm;
         void'(request_backlog.pop_front());
         valid_nxt = 1'b1;
      end
      req_valid <= valid_nxt;
      gap_left  <= gap_nxt;
   end

   // response monitor
   always @(posedge clock) begin
      slot_report_type got;
      slot_report_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_idle, rsp_run_id, rsp_slot_time, rsp_job_done, rsp_completion_time,
                   rsp_turnaround, rsp_waiting, rsp_all_done, rsp_total_waiting,
                   rsp_total_turnaround};
            rsp_count <= rsp_count + 1;
            if (slot_reports_due.size() == 0) begin
               report("response with none pending", 32'(got.slot_time), 32'd0);
            end else begin
               want = slot_reports_due.pop_front();
               if (got.idle !== want.idle)
                  report("idle", 32'(got.idle), 32'(want.idle));
               if (got.run_id !== want.run_id)
                  report("run_id", 32'(got.run_id), 32'(want.run_id));
               if (got.slot_time !== want.slot_time)
                  report("slot_time", 32'(got.slot_time), 32'(want.slot_time));
               if (got.job_done !== want.job_done)
                  report("job_done", 32'(got.job_done), 32'(want.job_done));
               if (got.completion_time !== want.completion_time)
                  report("completion_time", 32'(got.completion_time),
                         32'(want.completion_time));
               if (got.turnaround !== want.turnaround)
                  report("turnaround", 32'(got.turnaround), 32'(want.turnaround));
               if (got.waiting !== want.waiting)
                  report("waiting", 32'(got.waiting), 32'(want.waiting));
               if (got.all_done !== want.all_done)
                  report("all_done", 32'(got.all_done), 32'(want.all_done));
               if (got.total_waiting !== want.total_waiting)
                  report("total_waiting", 32'(got.total_waiting), 32'(want.total_waiting));
               if (got.total_turnaround !== want.total_turnaround)
                  report("total_turnaround", 32'(got.total_turnaround),
                         32'(want.total_turnaround));
            end
         end
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1'b1;
         end else if (!calm_phase && !cycle_count[9] && $urandom_range(0, 4) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= 2'($urandom_range(0, 2));
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      // empty table, then ties, lowest-slot wins and a finished table
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b0);
      push_load(8'h00, 16'h0000, 16'h0002, 1'b0, 1'b0);
      push_load(8'hFF, 16'h0003, 16'h0001, 1'b0, 1'b0);
      push_load(8'h5A, 16'h0001, 16'h0002, 1'b0, 1'b0);
      repeat (7) push_tick(1'b0, 1'b0);
      // load after ticks, then preempt with a shorter job that arrived in the past
      push_load(8'h81, 16'h0009, 16'h0003, 1'b0, 1'b0);
      push_tick(1'b0, 1'b0);
      push_load(8'h18, 16'h0000, 16'h0001, 1'b0, 1'b0);
      repeat (3) push_tick(1'b0, 1'b0);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (loaded_gen < EARLY_JOBS && $urandom_range(0, 69) == 0)
            random_load(k == 0, 1'b0);
         else
            push_tick(k == 0, 1'b0);
      end

      // drain, then run back to back
      push_tick(1'b1, 1'b1);

      // late arrivals, extremes, zero burst, full table
      push_load(8'hC3, 16'hFFFE, 16'h0005, 1'b1, 1'b1);
      push_load(8'h3C, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
      push_load(8'h11, 16'h1234, 16'h0002, 1'b0, 1'b1);
      push_load(8'h66, 16'h8000, 16'h0001, 1'b0, 1'b1);
      push_load(8'hE7, 16'h7FFF, 16'h0003, 1'b0, 1'b1);
      push_load(8'h77, 16'h0000, 16'h0000, 1'b0, 1'b1);
      while (loaded_gen < JOB_SLOTS) random_load(1'b0, 1'b1);
      repeat (2) random_load(1'b0, 1'b1);
      repeat (20) push_tick(1'b0, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || ticks_accepted != rsp_count);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (slot_reports_due.size() != 0)
         report("responses never returned", 32'(slot_reports_due.size()), 32'd0);

      if (mismatches == 0)
         $display("srtf_tick_scheduler_core regression: pass");
      else
         $display("srtf_tick_scheduler_core regression: fail");
      $finish;
   end

endmodule
